>>> rtl/core/hse_pkg.sv
// Shared types, command codes and compare helper for the heap sort engine.
// Used by hse_ctrl, hse_datapath and heap_sort_engine; no dependencies.
package hse_pkg;

	localparam int DATA_W = 32;

	// Datapath operations, one per cycle, issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_START,          // latch run size and order, first build index
		OP_BUILD_NODE,     // next build node, read its value
		OP_LD_CUR,         // capture value being sifted
		OP_RD_L,           // read left child
		OP_LD_L,           // capture left child (no right child)
		OP_LD_L_RD_R,      // capture left child, read right child
		OP_LD_R,           // take right child if it outranks the left
		OP_WR_CHILD,       // move winning child up, descend
		OP_WR_CUR,         // drop sifted value into its slot
		OP_EXT_INIT,       // start extraction at full heap size
		OP_RD_TOP,         // read heap root
		OP_LD_TOP_RD_LAST, // capture root, read last heap entry
		OP_EXTRACT,        // park root at end, shrink heap, sift from root
		OP_OUT_INIT,       // rewind output index
		OP_OUT_RD,         // read next sorted entry
		OP_OUT_LOAD        // load output register
	} op_t;

	typedef struct packed {
		op_t  op;
		logic take;        // input request accepted this cycle
	} cmd_t;

	typedef struct packed {
		logic build_done;
		logic extract_done;
		logic l_valid;
		logic r_valid;
		logic child_wins;
		logic out_free;
		logic out_last;
	} stat_t;

	// True if p must sit above q in the heap
	function automatic logic outranks(input logic signed [DATA_W-1:0] p,
			input logic signed [DATA_W-1:0] q, input logic maxheap);
		outranks = maxheap ? (p > q) : (q > p);
	endfunction

endpackage

>>> rtl/core/hse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/hse_datapath.sv
// Heap sort datapath: element store, index registers, compare and output register.
// Depends on hse_pkg and hse_ram; driven by hse_ctrl commands.
module hse_datapath #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hse_pkg::cmd_t                     cmd,
	output hse_pkg::stat_t                    stat,
	input  logic                              sort_ascending,
	input  logic signed [hse_pkg::DATA_W-1:0] in_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [hse_pkg::DATA_W-1:0] out_value,
	output logic                              out_last,
	output logic                              out_ovf
);
	import hse_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int XW = AW + 2;

	logic [CW-1:0] cnt_q, n_q, i_q, hs_q;
	logic          ovf_q, maxh_q;
	logic [AW-1:0] node_q, child_q, k_q;
	logic signed [DATA_W-1:0] cur_q, lv_q;

	logic [XW-1:0] l_x, r_x;
	logic [AW-1:0] l_a, r_a, im1_a;
	logic          room, r_wins;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic signed [DATA_W-1:0] wdata, rdata;
	logic          out_free, k_last;

	assign l_x   = {1'b0, node_q, 1'b1};
	assign r_x   = l_x + XW'(1);
	assign l_a   = l_x[AW-1:0];
	assign r_a   = r_x[AW-1:0];
	assign im1_a = AW'(i_q - CW'(1));
	assign room  = cnt_q < CW'(MAX_ELEMENTS);
	assign r_wins = outranks(rdata, lv_q, maxh_q);
	assign out_free = !out_valid || out_ready;
	assign k_last   = (CW'(k_q) + CW'(1)) == n_q;

	assign stat.build_done   = (i_q == '0);
	assign stat.extract_done = (i_q <= CW'(1));
	assign stat.l_valid      = l_x < XW'(hs_q);
	assign stat.r_valid      = r_x < XW'(hs_q);
	assign stat.child_wins   = outranks(lv_q, cur_q, maxh_q);
	assign stat.out_free     = out_free;
	assign stat.out_last     = k_last;

	// store port steering
	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = cur_q;
		re    = 1'b0;
		raddr = k_q;
		if (cmd.take && room) begin
			we    = 1'b1;
			waddr = cnt_q[AW-1:0];
			wdata = in_value;
		end
		case (cmd.op)
			OP_BUILD_NODE: begin
				re    = 1'b1;
				raddr = im1_a;
			end
			OP_RD_L: begin
				re    = 1'b1;
				raddr = l_a;
			end
			OP_LD_L_RD_R: begin
				re    = 1'b1;
				raddr = r_a;
			end
			OP_RD_TOP: begin
				re    = 1'b1;
				raddr = '0;
			end
			OP_LD_TOP_RD_LAST: begin
				re    = 1'b1;
				raddr = im1_a;
			end
			OP_OUT_RD: begin
				re    = 1'b1;
				raddr = k_q;
			end
			OP_WR_CHILD: begin
				we    = 1'b1;
				waddr = node_q;
				wdata = lv_q;
			end
			OP_WR_CUR: begin
				we    = 1'b1;
				waddr = node_q;
				wdata = cur_q;
			end
			OP_EXTRACT: begin
				we    = 1'b1;
				waddr = im1_a;
				wdata = lv_q;
			end
			default: begin
			end
		endcase
	end

	hse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ELEMENTS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// run bookkeeping and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.op == OP_OUT_LOAD) begin
				out_valid <= 1'b1;
				if (k_last) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// sort working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START: begin
				n_q    <= cnt_q;
				i_q    <= cnt_q >> 1;
				maxh_q <= sort_ascending;
			end
			OP_BUILD_NODE: begin
				node_q <= im1_a;
				hs_q   <= n_q;
				i_q    <= i_q - CW'(1);
			end
			OP_LD_CUR: cur_q <= rdata;
			OP_LD_L, OP_LD_L_RD_R: begin
				lv_q    <= rdata;
				child_q <= l_a;
			end
			OP_LD_R: begin
				if (r_wins) begin
					lv_q    <= rdata;
					child_q <= r_a;
				end
			end
			OP_WR_CHILD: node_q <= child_q;
			OP_EXT_INIT: i_q <= n_q;
			OP_LD_TOP_RD_LAST: lv_q <= rdata;
			OP_EXTRACT: begin
				cur_q  <= rdata;
				node_q <= '0;
				hs_q   <= i_q - CW'(1);
				i_q    <= i_q - CW'(1);
			end
			OP_OUT_INIT: k_q <= '0;
			OP_OUT_LOAD: begin
				out_value <= rdata;
				out_last  <= k_last;
				out_ovf   <= ovf_q;
				k_q       <= k_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ELEMENTS))
		else $error("element count beyond store depth");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (CW'(waddr) < CW'(MAX_ELEMENTS)))
		else $error("store write outside its depth");

	a_out_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT_LOAD) |-> (CW'(k_q) < n_q) && out_free)
		else $error("output loaded past the run or over a pending result");

	a_run_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_START) |-> (cnt_q != '0))
		else $error("sort started on an empty run");

endmodule

>>> rtl/core/hse_ctrl.sv
// Heap sort controller: load, heap build, extraction and output sequencing.
// Depends on hse_pkg; issues one hse_pkg::cmd_t per cycle to hse_datapath.
module hse_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	input  hse_pkg::stat_t stat,
	output hse_pkg::cmd_t  cmd
);
	import hse_pkg::*;

	typedef enum logic [13:0] {
		ST_LOAD   = 14'b00000000000001,
		ST_START  = 14'b00000000000010,
		ST_B_CHK  = 14'b00000000000100,
		ST_B_CUR  = 14'b00000000001000,
		ST_S_L    = 14'b00000000010000,
		ST_S_LV   = 14'b00000000100000,
		ST_S_RV   = 14'b00000001000000,
		ST_S_CMP  = 14'b00000010000000,
		ST_E_CHK  = 14'b00000100000000,
		ST_E_TOP  = 14'b00001000000000,
		ST_E_LAST = 14'b00010000000000,
		ST_O_INIT = 14'b00100000000000,
		ST_O_RD   = 14'b01000000000000,
		ST_O_WR   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   ext_q, ext_d;   // sift belongs to extraction phase
	state_t sift_ret;

	assign in_ready = (state_q == ST_LOAD);
	assign sift_ret = ext_q ? ST_E_CHK : ST_B_CHK;

	always_comb begin
		state_d  = state_q;
		ext_d    = ext_q;
		cmd.op   = OP_NONE;
		cmd.take = in_valid && in_ready;
		case (state_q)
			ST_LOAD: begin
				if (in_valid && in_last) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.op  = OP_START;
				ext_d   = 1'b0;
				state_d = ST_B_CHK;
			end
			ST_B_CHK: begin
				if (stat.build_done) begin
					cmd.op  = OP_EXT_INIT;
					ext_d   = 1'b1;
					state_d = ST_E_CHK;
				end else begin
					cmd.op  = OP_BUILD_NODE;
					state_d = ST_B_CUR;
				end
			end
			ST_B_CUR: begin
				cmd.op  = OP_LD_CUR;
				state_d = ST_S_L;
			end
			ST_S_L: begin
				if (stat.l_valid) begin
					cmd.op  = OP_RD_L;
					state_d = ST_S_LV;
				end else begin
					cmd.op  = OP_WR_CUR;
					state_d = sift_ret;
				end
			end
			ST_S_LV: begin
				if (stat.r_valid) begin
					cmd.op  = OP_LD_L_RD_R;
					state_d = ST_S_RV;
				end else begin
					cmd.op  = OP_LD_L;
					state_d = ST_S_CMP;
				end
			end
			ST_S_RV: begin
				cmd.op  = OP_LD_R;
				state_d = ST_S_CMP;
			end
			ST_S_CMP: begin
				if (stat.child_wins) begin
					cmd.op  = OP_WR_CHILD;
					state_d = ST_S_L;
				end else begin
					cmd.op  = OP_WR_CUR;
					state_d = sift_ret;
				end
			end
			ST_E_CHK: begin
				if (stat.extract_done) begin
					state_d = ST_O_INIT;
				end else begin
					cmd.op  = OP_RD_TOP;
					state_d = ST_E_TOP;
				end
			end
			ST_E_TOP: begin
				cmd.op  = OP_LD_TOP_RD_LAST;
				state_d = ST_E_LAST;
			end
			ST_E_LAST: begin
				cmd.op  = OP_EXTRACT;
				state_d = ST_S_L;
			end
			ST_O_INIT: begin
				cmd.op  = OP_OUT_INIT;
				state_d = ST_O_RD;
			end
			ST_O_RD: begin
				cmd.op  = OP_OUT_RD;
				state_d = ST_O_WR;
			end
			ST_O_WR: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT_LOAD;
					state_d = stat.out_last ? ST_LOAD : ST_O_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ext_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ext_q   <= ext_d;
		end
	end

	a_take_only_loading: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (state_q == ST_LOAD) && (cmd.op == OP_NONE))
		else $error("input taken while the store is busy");

	a_last_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && in_last) |=> (state_q == ST_START))
		else $error("final item did not start the sort");

	a_out_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT_LOAD) |-> $past(cmd.op == OP_OUT_RD) || $past(state_q == ST_O_WR))
		else $error("output loaded without a preceding store read");

endmodule

>>> rtl/core/heap_sort_engine.sv
// Heap sort engine top level: stream ports, APB order register, controller and datapath.
// Depends on hse_pkg, hse_ctrl, hse_datapath and hse_ram.
//
// Values stream in on the slave side, one request per cycle, into a store of
// MAX_ELEMENTS 32-bit entries; a request with tlast closes the run. Requests
// past the store's capacity are dropped and every result of that run then has
// tuser[0] (overflowed) set; the final request of a run still starts the sort
// even when it is dropped. The run is heap-sorted in place, ascending
// (max-heap) when the sort_ascending register is 1 and descending (min-heap)
// when it is 0; the register value seen at the start of the sort applies.
// Results leave on the master side in order, the final one with tlast.
// The store has a single read port with registered data, which sets the sort
// cost: each sift-down level reads the left child, reads the right child,
// compares, and moves the winning child up, and each sift ends with one
// write; each build node reads and captures the node's value, and each
// extraction reads the root, captures it while reading the last heap entry
// and parks it at the end. Each result is read from the store and then loaded
// into the output register, waiting while the master side stalls. The slave
// side takes no request from the final request of a run until the last result
// has been loaded into the output register; that result may still be waiting
// when loading resumes. The store needs no clearing after reset: only entries
// written in the current run are read.
module heap_sort_engine #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: tdata[31:0] = value; tlast = last
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	// master stream: tdata[31:0] = sorted_value; tlast = last_out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	// tuser[0] = overflowed
	output logic [0:0]  m_tuser,
	// APB configuration port, register 0 (sort_ascending) at byte address 0
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hse_pkg::*;

	logic  sort_ascending_q;
	cmd_t  cmd;
	stat_t stat;
	logic signed [DATA_W-1:0] out_value;
	logic  out_ovf;

	// Order register: word select on paddr[2], only bit 0 is kept
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {31'd0, sort_ascending_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_ascending_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			sort_ascending_q <= pwdata[0];
		end
	end

	hse_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_last (s_tlast),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	hse_datapath #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.sort_ascending(sort_ascending_q),
		.in_value      ($signed(s_tdata)),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_value     (out_value),
		.out_last      (m_tlast),
		.out_ovf       (out_ovf)
	);

	assign m_tdata    = out_value;
	assign m_tuser[0] = out_ovf;

endmodule

>>> verif/hse_checker.sv
// Scoreboard for heap_sort_engine: predicts each run's sorted output from the accepted
// requests and the order register, then compares it with the master-side results.
// Stand-alone module; the tb top supplies the order register address.
module hse_checker #(
	parameter int         CAPACITY       = 64,
	parameter logic [2:0] ORDER_REG_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	input  logic [0:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflowed;
	} sorted_result_t;

	sorted_result_t     sorted_queue[$];
	logic signed [31:0] run_values[CAPACITY];
	int                 run_count;
	logic               run_dropped;
	logic               order_ascending;

	// true if a must come after b in the output order
	function automatic logic comes_after(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic ascending);
		comes_after = ascending ? (a > b) : (a < b);
	endfunction

	// sort the held run and queue it as expected results
	task automatic emit_run();
		int                 i;
		int                 j;
		logic signed [31:0] key;
		sorted_result_t     res;
		for (i = 1; i < run_count; i++) begin
			key = run_values[i];
			j = i;
			while (j > 0 && comes_after(run_values[j-1], key, order_ascending)) begin
				run_values[j] = run_values[j-1];
				j--;
			end
			run_values[j] = key;
		end
		for (i = 0; i < run_count; i++) begin
			res.sorted_value = run_values[i];
			res.last_out = (i == run_count - 1);
			res.overflowed = run_dropped;
			sorted_queue.push_back(res);
		end
		run_count = 0;
		run_dropped = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_result_t want;
		if (!arst_n) begin
			sorted_queue.delete();
			run_count = 0;
			run_dropped = 1'b0;
			order_ascending = 1'b1;
			mismatches = 0;
			results_seen = 0;
		end else begin
			// word select on paddr[2]; byte offsets within the word alias
			if (psel && penable && pwrite && pready && paddr[2] == ORDER_REG_ADDR[2])
				order_ascending = pwdata[0];

			if (m_tvalid && m_tready) begin
				results_seen++;
				if (sorted_queue.size() == 0) begin
					$error("unexpected result: sorted_value=%0d", $signed(m_tdata));
					mismatches++;
				end else begin
					want = sorted_queue.pop_front();
					if (m_tdata !== want.sorted_value) begin
						$error("sorted_value: expected %0d, got %0d",
							want.sorted_value, $signed(m_tdata));
						mismatches++;
					end
					if (m_tlast !== want.last_out) begin
						$error("last_out: expected %0b, got %0b", want.last_out, m_tlast);
						mismatches++;
					end
					if (m_tuser[0] !== want.overflowed) begin
						$error("overflowed: expected %0b, got %0b",
							want.overflowed, m_tuser[0]);
						mismatches++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (run_count < CAPACITY) begin
					run_values[run_count] = s_tdata;
					run_count++;
				end else begin
					run_dropped = 1'b1;
				end
				if (s_tlast)
					emit_run();
			end
		end
		pending = sorted_queue.size();
	end

endmodule

>>> verif/tb.sv
// Top-level testbench for heap_sort_engine: clock, reset, stream and APB stimulus.
// Instantiates the block and hse_checker, which predicts and compares results;
// this module only drives requests and reports the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CAPACITY            = 64;
	// register 0 is the order bit; 4 maps to no register and must be ignored
	localparam logic [2:0] ADDR_SORT_ASCENDING = 3'd0;
	localparam logic [2:0] ADDR_UNMAPPED       = 3'd4;
	localparam int         SETTLE_CYCLES       = 16;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] sorted_value
	logic        m_tlast;
	logic [0:0]  m_tuser;   // [0] overflowed
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int pending;
	int results_seen;

	// idle probabilities in percent, changed only between phases
	int src_gap_pct;
	int sink_stall_pct;

	int requests_sent;
	int runs_sent;

	heap_sort_engine #(.MAX_ELEMENTS(CAPACITY)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	hse_checker #(.CAPACITY(CAPACITY), .ORDER_REG_ADDR(ADDR_SORT_ASCENDING)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .pending(pending), .results_seen(results_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// receiver back-pressure, re-rolled every cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("tb: errors");
		$finish;
	end

	// one request on the slave side; called and returns at a falling edge
	task automatic send_item(input logic [31:0] v, input logic l);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		requests_sent++;
		if (l)
			runs_sent++;
	endtask

	// full-range values half the time, else tiny ones for duplicates or one of the two extremes
	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0:       pick_value = $urandom_range(8) - 4;
			1:       pick_value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: pick_value = $urandom();
		endcase
	endfunction

	task automatic send_run(input int len);
		int k;
		for (k = 0; k < len; k++)
			send_item(pick_value(), k == len - 1);
	endtask

	// hold the sender until every predicted result has left the block
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int phase;
		int phase_items;
		int phase_runs;
		int len;
		int long_len[4];
		logic ascending;

		long_len = '{64, 65, 66, 70};
		requests_sent = 0;
		runs_sent = 0;
		src_gap_pct = 0;
		sink_stall_pct = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, order register at its reset value (ascending).
		// Both extremes, zero, one and minus one in one run.
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h0000_0001, 1'b1);
		// a run of one element
		send_item(32'd123, 1'b1);
		// equal values
		send_item(32'd5, 1'b0);
		send_item(32'd5, 1'b0);
		send_item(32'hFFFF_FFFB, 1'b1);
		drain();

		// only bit 0 counts: this selects descending; the unmapped write is a no-op
		apb_write(ADDR_SORT_ASCENDING, 32'hFFFF_FFFE);
		apb_write(ADDR_UNMAPPED, 32'h0000_0001);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h5555_5555, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b0);
		send_item(32'h0000_0000, 1'b1);
		drain();

		// Random part: four idle patterns, alternating sort order. Each phase
		// opens with a long run: exactly full, then final request dropped, then
		// deeper overflow, followed by short runs of random content.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin src_gap_pct = 0;  sink_stall_pct = 0;  end
				1:       begin src_gap_pct = 51; sink_stall_pct = 0;  end
				2:       begin src_gap_pct = 0;  sink_stall_pct = 51; end
				default: begin src_gap_pct = 29; sink_stall_pct = 29; end
			endcase
			ascending = !phase[0];
			apb_write(ADDR_SORT_ASCENDING, ($urandom() & 32'hFFFF_FFFE) | ascending);
			if ($urandom_range(1))
				apb_write(ADDR_UNMAPPED, $urandom());

			send_run(long_len[phase]);
			phase_items = long_len[phase];
			phase_runs = 0;
			while (phase_items < 85) begin
				len = $urandom_range(1, 10);
				send_run(len);
				phase_items += len;
				phase_runs++;
				// one full stop mid-phase so the block goes idle between runs
				if (phase_runs == 3)
					drain();
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("summary: %0d requests in %0d runs, %0d results checked",
			requests_sent, runs_sent, results_seen);
		$display("summary: both sort orders, full and overflowing store, four idle patterns");
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
